>>> src/mit_pkg.sv
// Shared types, sizes and the permutation table of the matrix inverse-transpose unit.
// Used by mit_ctrl, mit_datapath and matrix_inverse_transpose_unit; depends on nothing.
`timescale 1ns / 1ps
package mit_pkg;

   localparam int MAX_ORDER   = 4;
   localparam int FRAC_BITS   = 16;
   localparam int ELEM_W      = 32;
   localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int ROW_W       = $clog2(MAX_ORDER);
   localparam int LIMBS       = MAX_ORDER;
   localparam int LIMB_IDX_W  = $clog2(LIMBS);
   localparam int PROD_W      = ELEM_W * LIMBS;
   localparam int ACC_W       = PROD_W + 3;
   localparam int NUM_W       = ACC_W + 2 * FRAC_BITS;
   localparam int BIT_W       = $clog2(NUM_W);
   localparam int PERM_W      = 5;
   localparam int ORDER_W     = 3;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;
   localparam int QUO_W       = ELEM_W + 1;

   typedef enum logic [3:0] {
      S_LOAD, S_PSEL, S_ROW, S_MUL, S_ACC, S_SUM, S_DIV, S_ROUND, S_NEXT, S_EMIT
   } state_type;

   typedef struct packed {
      logic                odd;
      logic [3:0][1:0]     col;
   } perm_type;

   typedef struct packed {
      logic                load_en;
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
      logic                prod_init;
      logic                prod_odd;
      logic                mul_step;
      logic                mul_first;
      logic                acc_clear;
      logic                acc_add;
      logic                det_latch;
      logic                div_start;
      logic                div_step;
      logic                round_load;
      logic                zero_load;
      logic                out_last;
   } cmd_type;

   typedef struct packed {
      logic                singular;
   } status_type;

   function automatic perm_type mk_perm(input logic [1:0] c0, input logic [1:0] c1,
                                        input logic [1:0] c2, input logic [1:0] c3,
                                        input logic odd);
      perm_type p;
      p.col[0] = c0;
      p.col[1] = c1;
      p.col[2] = c2;
      p.col[3] = c3;
      p.odd    = odd;
      return p;
   endfunction

   // Permutations of order 2 come first, then the rest of order 3, then order 4.
   function automatic perm_type perm_entry(input logic [PERM_W-1:0] idx);
      perm_type p;
      unique case (idx)
         5'd0:    p = mk_perm(2'd0, 2'd1, 2'd2, 2'd3, 1'b0);
         5'd1:    p = mk_perm(2'd1, 2'd0, 2'd2, 2'd3, 1'b1);
         5'd2:    p = mk_perm(2'd0, 2'd2, 2'd1, 2'd3, 1'b1);
         5'd3:    p = mk_perm(2'd1, 2'd2, 2'd0, 2'd3, 1'b0);
         5'd4:    p = mk_perm(2'd2, 2'd0, 2'd1, 2'd3, 1'b0);
         5'd5:    p = mk_perm(2'd2, 2'd1, 2'd0, 2'd3, 1'b1);
         5'd6:    p = mk_perm(2'd0, 2'd1, 2'd3, 2'd2, 1'b1);
         5'd7:    p = mk_perm(2'd0, 2'd3, 2'd1, 2'd2, 1'b0);
         5'd8:    p = mk_perm(2'd1, 2'd0, 2'd3, 2'd2, 1'b0);
         5'd9:    p = mk_perm(2'd1, 2'd3, 2'd0, 2'd2, 1'b1);
         5'd10:   p = mk_perm(2'd3, 2'd0, 2'd1, 2'd2, 1'b1);
         5'd11:   p = mk_perm(2'd3, 2'd1, 2'd0, 2'd2, 1'b0);
         5'd12:   p = mk_perm(2'd0, 2'd2, 2'd3, 2'd1, 1'b0);
         5'd13:   p = mk_perm(2'd0, 2'd3, 2'd2, 2'd1, 1'b1);
         5'd14:   p = mk_perm(2'd2, 2'd0, 2'd3, 2'd1, 1'b1);
         5'd15:   p = mk_perm(2'd2, 2'd3, 2'd0, 2'd1, 1'b0);
         5'd16:   p = mk_perm(2'd3, 2'd0, 2'd2, 2'd1, 1'b0);
         5'd17:   p = mk_perm(2'd3, 2'd2, 2'd0, 2'd1, 1'b1);
         5'd18:   p = mk_perm(2'd1, 2'd2, 2'd3, 2'd0, 1'b1);
         5'd19:   p = mk_perm(2'd1, 2'd3, 2'd2, 2'd0, 1'b0);
         5'd20:   p = mk_perm(2'd2, 2'd1, 2'd3, 2'd0, 1'b0);
         5'd21:   p = mk_perm(2'd2, 2'd3, 2'd1, 2'd0, 1'b1);
         5'd22:   p = mk_perm(2'd3, 2'd1, 2'd2, 2'd0, 1'b1);
         5'd23:   p = mk_perm(2'd3, 2'd2, 2'd1, 2'd0, 1'b0);
         default: p = mk_perm(2'd0, 2'd1, 2'd2, 2'd3, 1'b0);
      endcase
      return p;
   endfunction

endpackage

>>> src/mit_ctrl.sv
// Sequencer of the matrix inverse-transpose unit: order register, handshakes and counters.
// Depends on mit_pkg; drives mit_datapath through cmd_type and reads status_type.
`timescale 1ns / 1ps
module mit_ctrl
   import mit_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last_element,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                csr_valid,
   input  logic [ORDER_W-1:0]  csr_matrix_order,
   output logic                csr_ready,
   output cmd_type             cmd,
   input  status_type          status
);

   state_type             state_ff, state_in;
   logic [ORDER_W-1:0]    order_ff;
   logic [PERM_W-1:0]     p_ff, p_in;
   logic [2:0]            r_ff, r_in;
   logic [LIMB_IDX_W-1:0] limb_ff, limb_in;
   logic [ROW_W-1:0]      i_ff, i_in, j_ff, j_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic                  cof_ff, cof_in;

   logic [2:0]            n;
   logic [ROW_W-1:0]      nm1;
   logic [PERM_W-1:0]     nperm;
   perm_type              pe;
   logic                  sel;
   logic [ROW_W-1:0]      row;
   logic [ADDR_W-1:0]     addr;
   logic                  final_ij;

   assign csr_ready = 1'b1;

   always_comb begin
      if (order_ff < 3'd2) begin
         n = 3'd2;
      end else if (order_ff > 3'(MAX_ORDER)) begin
         n = 3'(MAX_ORDER);
      end else begin
         n = order_ff;
      end
   end

   always_comb begin
      unique case (n)
         3'd2:    nperm = 5'd2;
         3'd3:    nperm = 5'd6;
         default: nperm = 5'd24;
      endcase
   end

   assign nm1      = ROW_W'(n - 3'd1);
   assign pe       = perm_entry(p_ff);
   assign sel      = !cof_ff || (pe.col[i_ff] == j_ff);
   assign row      = r_ff[ROW_W-1:0];
   assign addr     = ADDR_W'(ADDR_W'(row) * ADDR_W'(n)) + ADDR_W'(pe.col[row]);
   assign final_ij = (i_ff == nm1) && (j_ff == nm1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         order_ff <= ORDER_RESET;
         p_ff     <= '0;
         r_ff     <= '0;
         limb_ff  <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         bit_ff   <= '0;
         cof_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            order_ff <= csr_matrix_order;
         end
         p_ff    <= p_in;
         r_ff    <= r_in;
         limb_ff <= limb_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
         bit_ff  <= bit_in;
         cof_ff  <= cof_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      p_in      = p_ff;
      r_in      = r_ff;
      limb_in   = limb_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      bit_in    = bit_ff;
      cof_in    = cof_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.rd_addr  = addr;
      cmd.prod_odd = pe.odd;
      cmd.out_last = final_ij;
      unique case (state_ff)
         S_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_en = 1'b1;
               if (req_last_element) begin
                  cof_in        = 1'b0;
                  p_in          = '0;
                  cmd.acc_clear = 1'b1;
                  state_in      = S_PSEL;
               end
            end
         end
         S_PSEL: begin
            if (p_ff == nperm) begin
               state_in = S_SUM;
            end else if (sel) begin
               cmd.prod_init = 1'b1;
               r_in          = '0;
               state_in      = S_ROW;
            end else begin
               p_in = p_ff + 5'd1;
            end
         end
         S_ROW: begin
            if (r_ff == n) begin
               state_in = S_ACC;
            end else if (cof_ff && (row == i_ff)) begin
               r_in = r_ff + 3'd1;
            end else begin
               cmd.rd_en = 1'b1;
               limb_in   = '0;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_step  = 1'b1;
            cmd.mul_first = (limb_ff == '0);
            limb_in       = limb_ff + 1'b1;
            if (limb_ff == LIMB_IDX_W'(LIMBS - 1)) begin
               r_in     = r_ff + 3'd1;
               state_in = S_ROW;
            end
         end
         S_ACC: begin
            cmd.acc_add = 1'b1;
            p_in        = p_ff + 5'd1;
            state_in    = S_PSEL;
         end
         S_SUM: begin
            if (!cof_ff) begin
               cmd.det_latch = 1'b1;
               i_in          = '0;
               j_in          = '0;
               state_in      = S_NEXT;
            end else begin
               cmd.div_start = 1'b1;
               bit_in        = '0;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            bit_in       = bit_ff + 1'b1;
            if (bit_ff == BIT_W'(NUM_W - 1)) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round_load = 1'b1;
            state_in       = S_EMIT;
         end
         S_NEXT: begin
            if (status.singular) begin
               cmd.zero_load = 1'b1;
               state_in      = S_EMIT;
            end else begin
               cof_in        = 1'b1;
               p_in          = '0;
               cmd.acc_clear = 1'b1;
               state_in      = S_PSEL;
            end
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (final_ij) begin
                  state_in = S_LOAD;
               end else begin
                  if (j_ff == nm1) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
                  state_in = S_NEXT;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

endmodule

>>> src/mit_datapath.sv
// Datapath of the matrix inverse-transpose unit: element store, limb-serial multiplier,
// cofactor accumulator, bit-serial divider and result register. Depends on mit_pkg.
`timescale 1ns / 1ps
module mit_datapath
   import mit_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic signed [ELEM_W-1:0] req_element_value,
   input  logic                     req_last_element,
   output logic signed [ELEM_W-1:0] rsp_result_value,
   output logic                     rsp_last_result,
   output logic                     rsp_singular_or_saturated
);

   logic [ELEM_W-1:0]         mem [STORE_DEPTH];
   logic [CNT_W-1:0]          cnt_ff;
   logic [ELEM_W-1:0]         rd_ff;

   logic [PROD_W-1:0]         prod_ff;
   logic                      psign_ff;
   logic [ELEM_W-1:0]         carry_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]          dmag_ff;
   logic                      dneg_ff, dzero_ff;
   logic [NUM_W-1:0]          num_ff;
   logic [ACC_W:0]            rem_ff;
   logic [QUO_W-1:0]          q_ff;
   logic                      ovf_ff, cneg_ff;
   logic [ELEM_W-1:0]         val_ff;
   logic                      last_ff, flag_ff;

   logic [ELEM_W-1:0]         rd_mag;
   logic [2*ELEM_W-1:0]       mul_full;
   logic [ELEM_W-1:0]         carry_use;
   logic [ACC_W-1:0]          acc_mag;
   logic [ACC_W-1:0]          prod_ext;
   logic [ACC_W:0]            trial;
   logic                      ge;
   logic                      up;
   logic [QUO_W:0]            qr;
   logic                      neg;
   logic [QUO_W:0]            lim;
   logic                      sat;
   logic [ELEM_W-1:0]         mag_out;

   assign rd_mag    = rd_ff[ELEM_W-1] ? (~rd_ff + 1'b1) : rd_ff;
   assign carry_use = cmd.mul_first ? '0 : carry_ff;
   assign mul_full  = (2*ELEM_W)'(prod_ff[ELEM_W-1:0]) * (2*ELEM_W)'(rd_mag)
                      + (2*ELEM_W)'(carry_use);
   assign acc_mag   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign prod_ext  = ACC_W'(prod_ff);
   assign trial     = {rem_ff[ACC_W-1:0], num_ff[NUM_W-1]};
   assign ge        = trial >= {1'b0, dmag_ff};
   assign up        = {rem_ff[ACC_W-1:0], 1'b0} >= {1'b0, dmag_ff};
   assign qr        = {1'b0, q_ff} + (QUO_W+1)'(up);
   assign neg       = cneg_ff ^ dneg_ff;
   assign lim       = neg ? (QUO_W+1)'(34'h0_8000_0000) : (QUO_W+1)'(34'h0_7FFF_FFFF);
   assign sat       = ovf_ff || (qr > lim);
   assign mag_out   = sat ? lim[ELEM_W-1:0] : qr[ELEM_W-1:0];

   assign status.singular = dzero_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_en && (cnt_ff < CNT_W'(STORE_DEPTH))) begin
         mem[cnt_ff[ADDR_W-1:0]] <= req_element_value;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load_en) begin
         if (req_last_element) begin
            cnt_ff <= '0;
         end else if (cnt_ff < CNT_W'(STORE_DEPTH)) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prod_init) begin
         prod_ff  <= PROD_W'(1);
         psign_ff <= cmd.prod_odd;
      end else if (cmd.mul_step) begin
         prod_ff  <= {mul_full[ELEM_W-1:0], prod_ff[PROD_W-1:ELEM_W]};
         carry_ff <= mul_full[2*ELEM_W-1:ELEM_W];
         if (cmd.mul_first) begin
            psign_ff <= psign_ff ^ rd_ff[ELEM_W-1];
         end
      end
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff <= psign_ff ? (acc_ff - $signed(prod_ext)) : (acc_ff + $signed(prod_ext));
      end
      if (cmd.det_latch) begin
         dmag_ff  <= acc_mag;
         dneg_ff  <= acc_ff[ACC_W-1];
         dzero_ff <= (acc_ff == '0);
      end
      if (cmd.div_start) begin
         num_ff  <= {acc_mag, (2*FRAC_BITS)'(0)};
         cneg_ff <= acc_ff[ACC_W-1];
         rem_ff  <= '0;
         q_ff    <= '0;
         ovf_ff  <= 1'b0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         rem_ff <= ge ? (trial - {1'b0, dmag_ff}) : trial;
         q_ff   <= {q_ff[QUO_W-2:0], ge};
         ovf_ff <= ovf_ff | q_ff[QUO_W-1];
      end
      if (cmd.round_load) begin
         val_ff  <= neg ? (~mag_out + 1'b1) : mag_out;
         flag_ff <= sat;
         last_ff <= cmd.out_last;
      end else if (cmd.zero_load) begin
         val_ff  <= '0;
         flag_ff <= 1'b1;
         last_ff <= cmd.out_last;
      end
   end

   assign rsp_result_value          = $signed(val_ff);
   assign rsp_last_result           = last_ff;
   assign rsp_singular_or_saturated = flag_ff;

endmodule

>>> src/matrix_inverse_transpose_unit.sv
// Top level of the matrix inverse-transpose unit (orders 2 to 4, signed Q16.16).
// Depends on mit_pkg, mit_ctrl and mit_datapath.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  element_value, last_element
//   rsp      out        rsp_valid/rsp_stall  result_value, last_result, singular_or_saturated
//   csr      in         csr_valid/csr_ready  matrix_order
//
// Elements are taken while req_stall is low; on the marked element the determinant and
// each cofactor are summed over permutations, each factor taking a read and four limb-serial
// multiply steps, and each result adds a bit-serial divide. Synchronous reset sets the order to
// 3 and empties the load count. req_stall is high from the marked element until the last result
// is taken; a stalled result holds the sequencer.
`timescale 1ns / 1ps
module matrix_inverse_transpose_unit
   import mit_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_element_value,
   input  logic                     req_last_element,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ELEM_W-1:0] rsp_result_value,
   output logic                     rsp_last_result,
   output logic                     rsp_singular_or_saturated,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [ORDER_W-1:0]       csr_matrix_order
);

   cmd_type    cmd;
   status_type status;

   mit_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_last_element (req_last_element),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .csr_valid        (csr_valid),
      .csr_matrix_order (csr_matrix_order),
      .csr_ready        (csr_ready),
      .cmd              (cmd),
      .status           (status)
   );

   mit_datapath u_datapath (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .status                    (status),
      .req_element_value         (req_element_value),
      .req_last_element          (req_last_element),
      .rsp_result_value          (rsp_result_value),
      .rsp_last_result           (rsp_last_result),
      .rsp_singular_or_saturated (rsp_singular_or_saturated)
   );

endmodule

>>> tb/sv/tb_matrix_inverse_transpose_unit.sv
// Self-checking testbench for matrix_inverse_transpose_unit: it streams matrices of every order,
// predicts each inverse-transpose element with wide integer arithmetic and checks every result.
// Depends on mit_pkg and the RTL of the unit; it reads no files.
`timescale 1ns / 1ps

class inverse_transpose_board;
   typedef struct {
      logic [31:0] value;
      logic        last;
      logic        flag;
   } result_type;

   logic [31:0] store[16];
   bit          written[16];
   int          load_count;
   logic [2:0]  order;
   result_type  expected[$];
   int          errors;
   int          results_seen;
   int          matrices;
   int          singular_seen;
   int          saturated_seen;

   function new();
      load_count = 0;
      order = mit_pkg::ORDER_RESET;
      errors = 0;
      results_seen = 0;
      matrices = 0;
      singular_seen = 0;
      saturated_seen = 0;
      foreach (written[i]) written[i] = 0;
   endfunction

   function int order_used();
      if (order < 2) return 2;
      if (order > 4) return 4;
      return order;
   endfunction

   function bit covered(int count);
      for (int i = 0; i < count; i++) if (!written[i]) return 0;
      return 1;
   endfunction

   function logic signed [255:0] minor_det(int n, int rows[4], int cols[4], int k);
      logic signed [255:0] acc;
      logic signed [255:0] part;
      logic signed [255:0] elem;
      int sub_cols[4];
      int sub_rows[4];
      int t;
      if (k == 1) begin
         elem = $signed(store[(rows[0] * n + cols[0]) % 16]);
         return elem;
      end
      acc = 0;
      for (int i = 0; i < 4; i++) sub_rows[i] = (i < 3) ? rows[i + 1] : 0;
      for (int j = 0; j < k; j++) begin
         t = 0;
         sub_cols = '{default: 0};
         for (int c = 0; c < k; c++) if (c != j) begin
            sub_cols[t] = cols[c];
            t++;
         end
         part = minor_det(n, sub_rows, sub_cols, k - 1);
         elem = $signed(store[(rows[0] * n + cols[j]) % 16]);
         if (j % 2 == 1) acc = acc - part * elem;
         else acc = acc + part * elem;
      end
      return acc;
   endfunction

   function void note_element(logic [31:0] value, logic last);
      int n;
      int rs[4];
      int cs[4];
      int t;
      logic signed [255:0] det;
      logic signed [255:0] cof;
      logic [255:0] num;
      logic [255:0] den;
      logic [255:0] quo;
      logic [255:0] rem;
      logic [255:0] lim;
      bit neg;
      bit sat;
      result_type res;
      if (load_count < 16) begin
         store[load_count] = value;
         written[load_count] = 1;
         load_count++;
      end
      if (!last) return;
      load_count = 0;
      matrices++;
      n = order_used();
      for (int i = 0; i < 4; i++) rs[i] = i;
      det = minor_det(n, rs, rs, n);
      if (det == 0) singular_seen++;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            res.value = 0;
            res.last = (i == n - 1) && (j == n - 1);
            res.flag = (det == 0);
            if (det != 0) begin
               rs = '{default: 0};
               cs = '{default: 0};
               t = 0;
               for (int r = 0; r < n; r++) if (r != i) begin
                  rs[t] = r;
                  t++;
               end
               t = 0;
               for (int c = 0; c < n; c++) if (c != j) begin
                  cs[t] = c;
                  t++;
               end
               cof = minor_det(n, rs, cs, n - 1);
               if ((i + j) % 2 == 1) cof = -cof;
               neg = (cof < 0) != (det < 0);
               num = (cof < 0) ? -cof : cof;
               num = num << 32;
               den = (det < 0) ? -det : det;
               quo = num / den;
               rem = num % den;
               if ((rem << 1) >= den) quo = quo + 1;
               lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
               sat = quo > lim;
               if (sat) begin
                  quo = lim;
                  saturated_seen++;
               end
               res.value = neg ? -quo[31:0] : quo[31:0];
               res.flag = sat;
            end
            expected.push_back(res);
         end
      end
   endfunction

   function void check_result(logic [31:0] value, logic last, logic flag);
      result_type exp_res;
      results_seen++;
      if (expected.size() == 0) begin
         $error("unexpected result item: value %h last %b flag %b", value, last, flag);
         errors++;
         return;
      end
      exp_res = expected.pop_front();
      if (value !== exp_res.value) begin
         $error("result_value: expected %h, actual %h", exp_res.value, value);
         errors++;
      end
      if (last !== exp_res.last) begin
         $error("last_result: expected %b, actual %b", exp_res.last, last);
         errors++;
      end
      if (flag !== exp_res.flag) begin
         $error("singular_or_saturated: expected %b, actual %b", exp_res.flag, flag);
         errors++;
      end
   endfunction
endclass

module tb_matrix_inverse_transpose_unit;
   import mit_pkg::*;

   localparam int WATCHDOG_LIMIT = 60000;
   localparam int SETTLE_CYCLES  = 20;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [ELEM_W-1:0] req_element_value;
   logic                     req_last_element;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [ELEM_W-1:0] rsp_result_value;
   logic                     rsp_last_result;
   logic                     rsp_singular_or_saturated;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [ORDER_W-1:0]       csr_matrix_order;

   inverse_transpose_board board;
   int send_idle_pct;
   int stall_pct;
   int idle_cycles;
   int elements_sent;
   int orders_written;

   matrix_inverse_transpose_unit u_dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_element_value         (req_element_value),
      .req_last_element          (req_last_element),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_result_value          (rsp_result_value),
      .rsp_last_result           (rsp_last_result),
      .rsp_singular_or_saturated (rsp_singular_or_saturated),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_matrix_order          (csr_matrix_order)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
   end

   // Handshakes are sampled mid-cycle, where every signal is settled.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            board.check_result(rsp_result_value, rsp_last_result, rsp_singular_or_saturated);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("TB_ERROR");
               $finish;
            end
         end
      end
   end

   task automatic send_element(logic [31:0] value, logic last);
      bit taken;
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_element_value <= value;
      req_last_element <= last;
      forever begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
         if (taken) break;
      end
      board.note_element(value, last);
      elements_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.expected.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_order(logic [2:0] value);
      bit taken;
      drain();
      csr_valid <= 1'b1;
      csr_matrix_order <= value;
      forever begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
         if (taken) break;
      end
      csr_valid <= 1'b0;
      board.order = value;
      orders_written++;
   endtask

   task automatic send_matrix(logic [31:0] values[$]);
      foreach (values[i]) send_element(values[i], i == values.size() - 1);
   endtask

   function automatic logic [31:0] random_element(int shape, bit diagonal);
      logic [31:0] v;
      case (shape)
         0: v = ($urandom_range(0, 8) - 4) << 16;
         1: v = $urandom();
         2: v = $urandom_range(0, 3);
         default: v = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      endcase
      if (diagonal && shape == 0) v = v + (32'd12 << 16);
      return v;
   endfunction

   task automatic random_matrix();
      logic [31:0] values[$];
      int n;
      int shape;
      int kind;
      int len;
      n = board.order_used();
      kind = $urandom_range(0, 9);
      shape = $urandom_range(0, 3);
      for (int i = 0; i < n * n; i++) begin
         values.push_back(random_element(shape, (i / n) == (i % n)));
      end
      if (kind == 5) begin
         for (int j = 0; j < n; j++) values[n + j] = values[j];
      end else if (kind == 6) begin
         foreach (values[i]) values[i] = 0;
      end else if (kind == 7 && board.covered(16)) begin
         len = $urandom_range(1, n * n - 1);
         while (values.size() > len) void'(values.pop_back());
      end else if (kind == 8) begin
         len = $urandom_range(n * n + 1, 20);
         while (values.size() < len) values.push_back($urandom());
      end
      send_matrix(values);
   endtask

   initial begin
      logic [31:0] values[$];
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_element_value = '0;
      req_last_element = 1'b0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_matrix_order = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      idle_cycles = 0;
      elements_sent = 0;
      orders_written = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The reset order is three; extreme values sit off the diagonal.
      values = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0001,
                 32'h0000_0000, 32'h0000_0000, 32'h0002_0000};
      send_matrix(values);
      write_order(3'd2);
      values = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000};
      send_matrix(values);
      values = '{32'h0, 32'h0, 32'h0, 32'h0};
      send_matrix(values);
      values = '{32'h1, 32'h0, 32'h0, 32'hFFFF_FFFF};
      send_matrix(values);
      write_order(3'd4);
      values.delete();
      for (int i = 0; i < 16; i++) values.push_back((i % 5 == 0) ? 32'hFFFE_0000 : 32'h0);
      send_matrix(values);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 78 : (phase == 3) ? 10 : 0;
         stall_pct     = (phase == 2) ? 78 : (phase == 3) ? 10 : 0;
         while (elements_sent < 40 + 60 * (phase + 1)) begin
            if ($urandom_range(0, 4) == 0) write_order(3'($urandom_range(0, 7)));
            random_matrix();
         end
      end
      write_order(3'd0);
      random_matrix();
      write_order(3'd7);
      random_matrix();

      drain();
      repeat (200) @(posedge clock);
      $display("Covered %0d elements in %0d matrices with %0d order writes.",
               elements_sent, board.matrices, orders_written);
      $display("Checked %0d results: %0d singular matrices, %0d saturated values.",
               board.results_seen, board.singular_seen, board.saturated_seen);
      if (board.errors == 0 && board.expected.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
